[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands for the keypad scanner checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define KPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define KPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// kpd_pkg
// shared types, codes and helpers for the matrix keypad scanner
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

    // debounce phase codes
    localparam logic [2:0] PH_WAIT      = 3'd0;
    localparam logic [2:0] PH_START     = 3'd1;
    localparam logic [2:0] PH_SCAN      = 3'd2;
    localparam logic [2:0] PH_FOUND     = 3'd3;
    localparam logic [2:0] PH_PROCESSED = 3'd4;
    localparam logic [2:0] PH_END       = 3'd5;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SIXTEEN_KEY_MODE = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_PERIOD_MS = 2'd1;
    localparam logic [1:0] CFG_KEY_MAP_LOW      = 2'd2;
    localparam logic [1:0] CFG_KEY_MAP_HIGH     = 2'd3;

    localparam logic [7:0] SAMPLE_PERIOD_RESET = 8'd20;
    localparam logic [7:0] TICK_MAX            = 8'hFF;
    localparam logic [1:0] LAST_COLUMN         = 2'd3;
    localparam logic [3:0] DRIVE_NONE          = 4'hF;
    localparam logic [3:0] DRIVE_ALL           = 4'h0;

    typedef struct packed {
        logic        sixteen_key_mode;
        logic [7:0]  sample_period_ms;
        logic [63:0] key_map_low;
        logic [63:0] key_map_high;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic [3:0] row_lines;
    } req_t;

    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_ready;
        logic [7:0] key_code;
        logic [2:0] debounce_phase;
    } res_t;

    // highest active row wins
    function automatic logic [1:0] top_row(input logic [3:0] active);
        logic [1:0] row;
        if (active[3])      row = 2'd3;
        else if (active[2]) row = 2'd2;
        else if (active[1]) row = 2'd1;
        else                row = 2'd0;
        return row;
    endfunction

    // key index to mapped code, one byte per index
    function automatic logic [7:0] map_code(input logic [3:0] index,
                                            input logic [63:0] map_low,
                                            input logic [63:0] map_high);
        logic [63:0] word;
        word = index[3] ? map_high : map_low;
        return word[{index[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

[design/kpd_req_if.sv]
// ----------------------------------------------------------------------------
// kpd_req_if
// request channel: tick or acknowledge with row sample
// ----------------------------------------------------------------------------
`default_nettype none

interface kpd_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [3:0] row_lines;

    modport source (output valid, output operation, output row_lines, input ready);
    modport sink   (input valid, input operation, input row_lines, output ready);
endinterface

`default_nettype wire

[design/kpd_res_if.sv]
// ----------------------------------------------------------------------------
// kpd_res_if
// result channel: column drive, key status and debounce phase
// ----------------------------------------------------------------------------
`default_nettype none

interface kpd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] column_drive;
    logic       key_ready;
    logic [7:0] key_code;
    logic [2:0] debounce_phase;

    modport source (output valid, output column_drive, output key_ready,
                    output key_code, output debounce_phase, input ready);
    modport sink   (input valid, input column_drive, input key_ready,
                    input key_code, input debounce_phase, output ready);
endinterface

`default_nettype wire

[design/kpd_cfg_if.sv]
// ----------------------------------------------------------------------------
// kpd_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface kpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/matrix_keypad_scan_debounce.sv]
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce
// debounced 4x4 keypad scanner driven by millisecond tick requests
// ----------------------------------------------------------------------------
//
//  channel  dir   carries                                         width
//  req      in    operation, row_lines                            1 + 4
//  res      out   column_drive, key_ready, key_code, phase        4+1+8+3
//  cfg      in    index, data (write only)                        2 + 64
//
//  one request in, one result out, one request per cycle sustained while results are taken
//  each request passes the request register, then the state update into the result register
//  a waiting result stalls the input once the request register also holds one
//  async reset: phase wait, tick count and column zero, period 20, maps zero
//  cfg writes are always taken and go straight into the config registers
//
`default_nettype none

module matrix_keypad_scan_debounce
    import kpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    kpd_req_if.sink   req,
    kpd_res_if.source res,
    kpd_cfg_if.sink   cfg
);

    // request register
    logic in_valid_reg;
    req_t in_req_reg;

    // result register
    logic out_valid_reg;
    res_t out_res_reg;

    cfg_t cfg_cur;
    res_t core_res;
    logic advance;

    // move the held request into the result register when it is free
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    kpd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    // state only updates when its result is committed
    kpd_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .req_in  (in_req_reg),
        .cfg_in  (cfg_cur),
        .res_out (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_req_reg.operation <= req.operation;
            in_req_reg.row_lines <= req.row_lines;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign res.valid          = out_valid_reg;
    assign res.column_drive   = out_res_reg.column_drive;
    assign res.key_ready      = out_res_reg.key_ready;
    assign res.key_code       = out_res_reg.key_code;
    assign res.debounce_phase = out_res_reg.debounce_phase;

endmodule

`default_nettype wire

[design/kpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// kpd_cfg_regs
// configuration register bank, always ready for a write
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_cfg_regs
    import kpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    kpd_cfg_if.sink   cfg,
    output cfg_t      cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SIXTEEN_KEY_MODE: cfg_next.sixteen_key_mode = cfg.data[0];
                CFG_SAMPLE_PERIOD_MS: cfg_next.sample_period_ms = cfg.data[7:0];
                CFG_KEY_MAP_LOW:      cfg_next.key_map_low      = cfg.data;
                CFG_KEY_MAP_HIGH:     cfg_next.key_map_high     = cfg.data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sixteen_key_mode <= 1'b0;
            cfg_reg.sample_period_ms <= SAMPLE_PERIOD_RESET;
            cfg_reg.key_map_low      <= '0;
            cfg_reg.key_map_high     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[design/kpd_core.sv]
// ----------------------------------------------------------------------------
// kpd_core
// debounce state machine, tick counter and column scan
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_core
    import kpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire req_t req_in,
    input  wire cfg_t cfg_in,
    output res_t      res_out
);

    logic [2:0] phase_reg,    phase_next;
    logic [7:0] tick_reg,     tick_next;
    logic [1:0] column_reg,   column_next;
    logic [7:0] code_reg,     code_next;

    logic [3:0] active;
    logic [7:0] tick_inc;
    logic       sample;
    logic [1:0] column;

    assign active   = ~req_in.row_lines;
    assign tick_inc = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 8'd1;
    assign sample   = (tick_inc >= cfg_in.sample_period_ms);
    assign column   = cfg_in.sixteen_key_mode ? column_reg : 2'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        column_next = column_reg;
        code_next   = code_reg;
        if (req_in.operation == OP_ACK)
        begin
            phase_next = PH_PROCESSED;
        end
        else
        begin
            tick_next = sample ? 8'd0 : tick_inc;
            if (phase_reg == PH_SCAN)
            begin
                if (active != 4'd0)
                begin
                    code_next  = map_code({column, top_row(active)},
                                          cfg_in.key_map_low, cfg_in.key_map_high);
                    phase_next = PH_FOUND;
                end
                else if (!cfg_in.sixteen_key_mode || column == LAST_COLUMN)
                begin
                    code_next  = 8'd0;
                    phase_next = PH_FOUND;
                end
                else
                begin
                    column_next = column + 2'd1;
                end
            end
            else if (sample)
            begin
                case (phase_reg)
                    PH_WAIT:
                        if (active != 4'd0) phase_next = PH_START;
                    PH_START:
                        if (active != 4'd0)
                        begin
                            phase_next  = PH_SCAN;
                            column_next = 2'd0;
                        end
                    PH_PROCESSED:
                        if (active == 4'd0) phase_next = PH_END;
                    PH_END:
                        if (active == 4'd0) phase_next = PH_WAIT;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // result reflects the state after this request
    always_comb
    begin
        if (!cfg_in.sixteen_key_mode)
            res_out.column_drive = DRIVE_NONE;
        else if (phase_next == PH_SCAN)
            res_out.column_drive = ~(4'b0001 << column_next);
        else
            res_out.column_drive = DRIVE_ALL;
        res_out.key_ready      = (phase_next == PH_FOUND);
        res_out.key_code       = code_next;
        res_out.debounce_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            tick_reg   <= 8'd0;
            column_reg <= 2'd0;
            code_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            column_reg <= column_next;
            code_reg   <= code_next;
        end
    end

endmodule

`default_nettype wire

[design/kpd_checker.sv]
// ----------------------------------------------------------------------------
// kpd_checker
// port-level checks on the keypad scanner result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kpd_checker
    import kpd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [3:0] column_drive,
    input wire logic       key_ready,
    input wire logic [7:0] key_code,
    input wire logic [2:0] debounce_phase
);

    `KPD_ASSERT_IMP(a_ready_is_found, clk, rst_n, res_valid, key_ready == (debounce_phase == PH_FOUND), "key_ready out of step with found phase")

    `KPD_ASSERT_IMP(a_scan_one_column, clk, rst_n, res_valid && debounce_phase == PH_SCAN, column_drive == DRIVE_NONE || $countones(column_drive) == 3, "scan drives other than one column")

    `KPD_ASSERT_IMP(a_idle_drive, clk, rst_n, res_valid && debounce_phase != PH_SCAN, column_drive == DRIVE_ALL || column_drive == DRIVE_NONE, "column drive outside scan not all or none")

    `KPD_ASSERT_NXT(a_stall_holds, clk, rst_n, res_valid && !res_ready, res_valid && $stable({column_drive, key_ready, key_code, debounce_phase}), "stalled result changed")

endmodule

bind matrix_keypad_scan_debounce kpd_checker u_kpd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .column_drive   (res.column_drive),
    .key_ready      (res.key_ready),
    .key_code       (res.key_code),
    .debounce_phase (res.debounce_phase)
);

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the debounced keypad scanner: a behavioural
// mirror of the scanner predicts every report, requests come from an
// emulated keypad with bounce and noise, both channels idle at random
// ----------------------------------------------------------------------------

module testbench;

    import kpd_pkg::*;

    logic clk;
    logic rst_n;

    kpd_req_if req_ch();
    kpd_res_if res_ch();
    kpd_cfg_if cfg_ch();

    matrix_keypad_scan_debounce dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // mirror of the configuration registers
    logic        mirror_sixteen;
    logic [7:0]  mirror_period;
    logic [63:0] mirror_map_low;
    logic [63:0] mirror_map_high;

    // mirror of the scanner state
    logic [2:0]  scan_phase;
    logic [7:0]  scan_ticks;
    logic [1:0]  scan_col;
    logic [7:0]  scan_code;

    // reports predicted for accepted requests, oldest first
    res_t awaited_reports[$];

    int  error_count;
    int  reports_seen;
    int  requests_sent;
    bit  sender_idling;
    bit  receiver_idling;
    int  hold_off_request;

    // ------------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // far beyond the slowest legal run, even with every gap and stall at its longest
    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // scanner mirror
    // ------------------------------------------------------------------------

    // column pins as the scanner drives them in its present state
    function automatic logic [3:0] drive_now();
        if (!mirror_sixteen)
            return DRIVE_NONE;
        else if (scan_phase == PH_SCAN)
            return ~(4'b0001 << scan_col);
        else
            return DRIVE_ALL;
    endfunction

    // mapped code for a column and its active rows, highest row wins
    function automatic logic [7:0] key_code_of(input logic [1:0] col,
                                               input logic [3:0] active);
        logic [1:0]   row;
        logic [127:0] codes;
        row = 2'd0;
        for (int r = 0; r < 4; r++)
            if (active[r])
                row = r[1:0];
        codes = {mirror_map_high, mirror_map_low};
        return codes[{col, row, 3'b000} +: 8];
    endfunction

    // advance the mirror by one request and queue the report it gives
    function automatic void step_scanner(input logic op, input logic [3:0] rows);
        logic [3:0] active;
        logic       sampled;
        logic [1:0] col;
        res_t       report;
        active = ~rows;
        if (op == OP_ACK)
        begin
            // acknowledge wins in any phase, even mid scan, and stops the tick count
            scan_phase = PH_PROCESSED;
        end
        else
        begin
            if (scan_ticks != TICK_MAX)
                scan_ticks = scan_ticks + 8'd1;
            sampled = (scan_ticks >= mirror_period);
            if (sampled)
                scan_ticks = '0;
            if (scan_phase == PH_SCAN)
            begin
                // every tick scans one column, the debounce machine rests
                col = mirror_sixteen ? scan_col : 2'd0;
                if (active != 4'h0)
                begin
                    scan_code  = key_code_of(col, active);
                    scan_phase = PH_FOUND;
                end
                else if (!mirror_sixteen || col == LAST_COLUMN)
                begin
                    // nothing in any column: report code zero
                    scan_code  = 8'h00;
                    scan_phase = PH_FOUND;
                end
                else
                begin
                    scan_col = col + 2'd1;
                end
            end
            else if (sampled)
            begin
                if (active != 4'h0 && scan_phase == PH_WAIT)
                    scan_phase = PH_START;
                else if (active != 4'h0 && scan_phase == PH_START)
                begin
                    scan_phase = PH_SCAN;
                    scan_col   = 2'd0;
                end
                else if (active == 4'h0 && scan_phase == PH_PROCESSED)
                    scan_phase = PH_END;
                else if (active == 4'h0 && scan_phase == PH_END)
                    scan_phase = PH_WAIT;
            end
        end
        report.column_drive   = drive_now();
        report.key_ready      = (scan_phase == PH_FOUND);
        report.key_code       = scan_code;
        report.debounce_phase = scan_phase;
        awaited_reports.push_back(report);
    endfunction

    // row pins seen under the present column drive with the given keys held
    function automatic logic [3:0] keypad_rows(input logic [15:0] pressed);
        logic [3:0] drive;
        logic [3:0] rows;
        drive = drive_now();
        rows  = 4'hF;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                // four-key mode: keys sit on a common line, only column 0 exists
                if ((mirror_sixteen ? !drive[c] : (c == 0)) && pressed[4 * c + r])
                    rows[r] = 1'b0;
            end
        return rows;
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------

    // offer one request, hold it until taken, then let the mirror see it
    task automatic send_request(input logic op, input logic [3:0] rows);
        int gap;
        if (sender_idling && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 18);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.row_lines <= rows;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        step_scanner(op, rows);
        requests_sent++;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SIXTEEN_KEY_MODE: mirror_sixteen  = value[0];
            CFG_SAMPLE_PERIOD_MS: mirror_period   = value[7:0];
            CFG_KEY_MAP_LOW:      mirror_map_low  = value;
            CFG_KEY_MAP_HIGH:     mirror_map_high = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // wait until every predicted report is in and the pipeline is empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // all four registers; unused upper bits of the narrow ones carry junk
    task automatic configure(input logic sixteen, input logic [7:0] period,
                             input logic [63:0] map_low, input logic [63:0] map_high);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_register(CFG_SIXTEEN_KEY_MODE, {junk[63:1], sixteen});
        write_register(CFG_SAMPLE_PERIOD_MS, {junk[63:8], period});
        write_register(CFG_KEY_MAP_LOW, map_low);
        write_register(CFG_KEY_MAP_HIGH, map_high);
    endtask

    // ------------------------------------------------------------------------
    // stimulus building blocks
    // ------------------------------------------------------------------------

    // one press held through debounce and scan, acknowledge, then release
    task automatic keystroke();
        logic [15:0] pressed;
        logic [3:0]  rows;
        int          pace;
        int          spread;
        int          hold;
        pace    = (mirror_period == 8'd0) ? 1 : int'(mirror_period);
        spread  = (pace > 8) ? 8 : pace;
        pressed = 16'd1 << (mirror_sixteen ? $urandom_range(0, 15) : $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
            pressed = pressed | (16'd1 << $urandom_range(0, 15));
        hold = 2 * pace + $urandom_range(0, 2 * spread) + 4;
        for (int n = 0; n < hold; n++)
        begin
            rows = keypad_rows(pressed);
            // contact bounce
            if ($urandom_range(0, 9) == 0)
                rows = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 39) == 0)
                send_request(OP_ACK, rows);
            else
                send_request(OP_TICK, rows);
        end
        // software usually takes the key, sometimes twice, sometimes never
        if ($urandom_range(0, 7) != 0)
            send_request(OP_ACK, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 9) == 0)
            send_request(OP_ACK, 4'($urandom_range(0, 15)));
        hold = pace + $urandom_range(0, 2 * spread) + 2;
        for (int n = 0; n < hold; n++)
        begin
            rows = keypad_rows(16'h0000);
            if ($urandom_range(0, 11) == 0)
                rows = 4'($urandom_range(0, 15));
            send_request(OP_TICK, rows);
        end
    endtask

    // unstructured requests
    task automatic noise_burst();
        int count;
        count = $urandom_range(1, 12);
        repeat (count)
            send_request(($urandom_range(0, 3) == 0) ? OP_ACK : OP_TICK,
                         4'($urandom_range(0, 15)));
    endtask

    task automatic run_sessions(input int count);
        int first;
        first = requests_sent;
        while (requests_sent - first < count)
        begin
            if ($urandom_range(0, 4) == 0)
                noise_burst();
            else
                keystroke();
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // press, debounce, scan to column 1 with two rows active, acknowledge, release
    task automatic test_sixteen_key_scan();
        configure(1'b1, 8'd1, 64'h1716151413121110, 64'h1F1E1D1C1B1A1918);
        send_request(OP_TICK, 4'hF);
        send_request(OP_TICK, 4'b1110);    // row 0 down: start
        send_request(OP_TICK, 4'b0000);    // all rows down: scan
        send_request(OP_TICK, 4'hF);       // column 0 empty
        send_request(OP_TICK, 4'b0110);    // rows 0 and 3 in column 1, row 3 wins
        send_request(OP_ACK,  4'b0000);
        send_request(OP_TICK, 4'b0000);    // still held: stays processed
        send_request(OP_TICK, 4'hF);       // released: end
        send_request(OP_TICK, 4'hF);       // still released: wait
        settle();
    endtask

    // scan runs through all four columns and finds nothing
    task automatic test_empty_column_scan();
        send_request(OP_TICK, 4'b1110);
        send_request(OP_TICK, 4'b1110);
        repeat (4)
            send_request(OP_TICK, 4'hF);
        send_request(OP_ACK, 4'hF);
        settle();
    endtask

    // no column drive, zero period, acknowledge while processed, start without press
    task automatic test_four_key_mode();
        configure(1'b0, 8'd0, 64'h1716151413121110, 64'h1F1E1D1C1B1A1918);
        send_request(OP_TICK, 4'b0111);    // held over from the last test: stays processed
        send_request(OP_TICK, 4'b0111);    // still held: stays processed
        send_request(OP_ACK,  4'b0111);    // acknowledge while processed
        send_request(OP_TICK, 4'hF);
        send_request(OP_TICK, 4'hF);       // back to wait
        send_request(OP_TICK, 4'b1011);    // start
        send_request(OP_TICK, 4'hF);       // no press: start holds
        send_request(OP_TICK, 4'b1011);    // scan
        send_request(OP_TICK, 4'b1101);    // first scan tick finds row 1
        send_request(OP_ACK,  4'hF);
        settle();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        configure(1'b1, 8'd2, {$urandom, $urandom}, {$urandom, $urandom});
        sender_idling    = 1'b0;
        hold_off_request = 60;
        repeat (3)
            keystroke();
        sender_idling = 1'b1;
        settle();
    endtask

    // a run of settings with random keypad traffic, extremes included
    task automatic test_random_settings();
        logic        sixteen;
        logic [7:0]  period;
        logic [63:0] map_low;
        logic [63:0] map_high;
        for (int ph = 0; ph < 9; ph++)
        begin
            sixteen  = 1'($urandom_range(0, 1));
            map_low  = {$urandom, $urandom};
            map_high = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       period = 8'd0;
                1:       period = 8'd1;
                5:       period = 8'($urandom_range(6, 12));
                default: period = 8'($urandom_range(2, 5));
            endcase
            if (ph == 0)
            begin
                sixteen  = 1'b1;
                period   = 8'd1;
                map_low  = '1;
                map_high = '1;
            end
            else if (ph == 1)
            begin
                sixteen  = 1'b0;
                period   = 8'd0;
                map_low  = '0;
                map_high = '0;
            end
            settle();
            configure(sixteen, period, map_low, map_high);
            run_sessions(110);
        end
        // longest sample period: one slow keystroke
        settle();
        configure(1'b1, 8'd255, {$urandom, $urandom}, {$urandom, $urandom});
        keystroke();
        settle();
    endtask

    // closing stretch with both channels running flat out
    task automatic test_no_idle();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        configure(1'b1, 8'($urandom_range(1, 3)), {$urandom, $urandom},
                  {$urandom, $urandom});
        run_sessions(150);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // receiver: ready with random stall bursts and requested long hold-offs
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request != 0)
            begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (receiver_idling && $urandom_range(0, 11) == 0)
            begin
                stall_left   = $urandom_range(1, 18) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // report checker: every taken report against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            reports_seen++;
            if (awaited_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("report %0d arrived with none predicted: phase %0d code %h",
                             reports_seen, res_ch.debounce_phase, res_ch.key_code);
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (res_ch.column_drive !== want.column_drive
                    || res_ch.key_ready !== want.key_ready
                    || res_ch.key_code !== want.key_code
                    || res_ch.debounce_phase !== want.debounce_phase)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"report %0d mismatch: expected drive %h ready %b code %h ",
                                  "phase %0d, got drive %h ready %b code %h phase %0d"},
                                 reports_seen, want.column_drive, want.key_ready,
                                 want.key_code, want.debounce_phase, res_ch.column_drive,
                                 res_ch.key_ready, res_ch.key_code, res_ch.debounce_phase);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_TICK;
        req_ch.row_lines <= 4'hF;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_SIXTEEN_KEY_MODE;
        cfg_ch.data      <= '0;

        // mirror starts in the reset state
        mirror_sixteen   = 1'b0;
        mirror_period    = SAMPLE_PERIOD_RESET;
        mirror_map_low   = '0;
        mirror_map_high  = '0;
        scan_phase       = PH_WAIT;
        scan_ticks       = '0;
        scan_col         = '0;
        scan_code        = '0;
        error_count      = 0;
        reports_seen     = 0;
        requests_sent    = 0;
        hold_off_request = 0;
        sender_idling    = 1'b1;
        receiver_idling  = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sixteen_key_scan();
        test_empty_column_scan();
        test_four_key_mode();
        test_backpressure();
        test_random_settings();
        test_no_idle();

        // let any stray report show itself
        settle();
        repeat (8) @(posedge clk);
        if (awaited_reports.size() != 0)
        begin
            error_count++;
            $display("%0d predicted reports never arrived", awaited_reports.size());
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
